// ----- src/htbd_pkg.sv -----
// ----------------------------------------------------------------------------
// htbd_pkg
// Shared types and constants for the code tree bit decoder.
// ----------------------------------------------------------------------------
package htbd_pkg;

	localparam int NODE_COUNT   = 512;
	localparam int MAX_CODE_LEN = 16;
	localparam int CODE_W       = 16;
	localparam int LEN_W        = 5;
	localparam int SYM_W        = 8;
	localparam int STAT_W       = 2;
	localparam int NODE_W       = $clog2(NODE_COUNT);
	localparam int USED_W       = $clog2(NODE_COUNT + 1);
	localparam int CIDX_W       = $clog2(CODE_W);
	localparam int LEN_LIM      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_PATH = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic              operation;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  code_len;
		logic              bit_req;
	} in_item_t;

	typedef struct packed {
		logic [SYM_W-1:0]  decoded_symbol;
		logic [STAT_W-1:0] status;
	} out_item_t;

	typedef struct packed {
		logic              capture;
		logic              clr_step;
		logic              walk;
		logic              sym_wr;
		logic              dec_step;
		logic              cur_root;
		logic              cur_node;
		logic              out_load;
		logic [STAT_W-1:0] out_code;
	} dp_cmd_t;

	typedef struct packed {
		logic in_len_zero;
		logic child_absent;
		logic store_full;
		logic is_leaf;
		logic walk_last;
		logic clr_last;
	} dp_stat_t;

endpackage

// ----- src/huffman_tree_bit_decoder_top.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_top
// Binary code tree builder and bit-at-a-time symbol decoder.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_item) takes load transactions, which
// walk the tree from the root along code_len code bits MSB first and
// allocate missing nodes, and decode transactions, which step one bit from
// the current node. Output channel (out_valid/out_stall/out_item) carries a
// symbol when a decode reaches a childless node, a bad path status when a
// decode finds no child, or a full status when a load runs out of nodes.
// One transaction is handled at a time; each node visit is a read of the
// node store with registered read data. A decode reads the current node
// and gives a bad path status if the child for its bit is missing; else
// it reads the child and gives its symbol if it is a leaf, or keeps it as
// the current node. A load visits one node per code bit, up to 16 bits.
// A result is held in the output register while out_stall is high; the
// next transaction is taken meanwhile and only waits if it must produce a
// result of its own before the held one has left.
// After arst_n the node store is swept to zero, one node per cycle, and
// in_stall stays high until all 512 nodes have been cleared.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  htbd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output htbd_pkg::out_item_t out_item
);

	htbd_pkg::dp_cmd_t  cmd;
	htbd_pkg::dp_stat_t stat;

	htbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_item.operation),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	htbd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (out_item)
	);

endmodule

// ----- src/htbd_ram.sv -----
// ----------------------------------------------------------------------------
// htbd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module htbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/htbd_datapath.sv -----
// ----------------------------------------------------------------------------
// htbd_datapath
// Node store, walk registers and result register of the code tree decoder.
// ----------------------------------------------------------------------------
module htbd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  htbd_pkg::in_item_t  in_item,
	input  htbd_pkg::dp_cmd_t   cmd,
	output htbd_pkg::dp_stat_t  stat,
	output htbd_pkg::out_item_t out_item
);

	logic [htbd_pkg::NODE_W-1:0] node_q;
	logic [htbd_pkg::NODE_W-1:0] cur_q;
	logic [htbd_pkg::USED_W-1:0] used_q;
	logic [htbd_pkg::LEN_W-1:0]  cnt_q;
	logic                        op_q;
	logic                        bit_q;
	logic [htbd_pkg::SYM_W-1:0]  sym_q;
	logic [htbd_pkg::CODE_W-1:0] code_q;

	logic [htbd_pkg::NODE_W-1:0] left_rd;
	logic [htbd_pkg::NODE_W-1:0] right_rd;
	logic [htbd_pkg::SYM_W-1:0]  sym_rd;
	logic [htbd_pkg::NODE_W-1:0] child;
	logic [htbd_pkg::NODE_W-1:0] link_wdata;
	logic [htbd_pkg::SYM_W-1:0]  sym_wdata;
	logic [htbd_pkg::LEN_W-1:0]  len_sat;
	logic [htbd_pkg::CIDX_W-1:0] code_idx;
	logic                        dir;
	logic                        absent;
	logic                        we_left;
	logic                        we_right;
	logic                        we_sym;

	assign code_idx   = htbd_pkg::CIDX_W'(cnt_q - htbd_pkg::LEN_W'(1));
	assign dir        = (op_q == htbd_pkg::OP_DECODE) ? bit_q : code_q[code_idx];
	assign child      = dir ? right_rd : left_rd;
	assign absent     = (child == '0);
	assign link_wdata = cmd.clr_step ? '0 : used_q[htbd_pkg::NODE_W-1:0];
	assign sym_wdata  = cmd.clr_step ? '0 : sym_q;
	assign we_left    = cmd.clr_step | (cmd.walk & absent & ~dir);
	assign we_right   = cmd.clr_step | (cmd.walk & absent & dir);
	assign we_sym     = cmd.clr_step | cmd.sym_wr;
	assign len_sat    = (in_item.code_len > htbd_pkg::LEN_W'(htbd_pkg::LEN_LIM)) ?
		htbd_pkg::LEN_W'(htbd_pkg::LEN_LIM) : in_item.code_len;

	htbd_ram #(.WIDTH(htbd_pkg::NODE_W), .DEPTH(htbd_pkg::NODE_COUNT)) u_left (
		.clk   (clk),
		.we    (we_left),
		.waddr (node_q),
		.wdata (link_wdata),
		.raddr (node_q),
		.rdata (left_rd)
	);

	htbd_ram #(.WIDTH(htbd_pkg::NODE_W), .DEPTH(htbd_pkg::NODE_COUNT)) u_right (
		.clk   (clk),
		.we    (we_right),
		.waddr (node_q),
		.wdata (link_wdata),
		.raddr (node_q),
		.rdata (right_rd)
	);

	htbd_ram #(.WIDTH(htbd_pkg::SYM_W), .DEPTH(htbd_pkg::NODE_COUNT)) u_sym (
		.clk   (clk),
		.we    (we_sym),
		.waddr (node_q),
		.wdata (sym_wdata),
		.raddr (node_q),
		.rdata (sym_rd)
	);

	always_comb begin
		stat.in_len_zero  = (in_item.code_len == '0);
		stat.child_absent = absent;
		stat.store_full   = (used_q == htbd_pkg::USED_W'(htbd_pkg::NODE_COUNT));
		stat.is_leaf      = (left_rd == '0) && (right_rd == '0);
		stat.walk_last    = (cnt_q == htbd_pkg::LEN_W'(1));
		stat.clr_last     = (node_q == htbd_pkg::NODE_W'(htbd_pkg::NODE_COUNT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
			cur_q  <= '0;
			used_q <= htbd_pkg::USED_W'(1);
			cnt_q  <= '0;
			op_q   <= htbd_pkg::OP_LOAD;
		end else begin
			if (cmd.capture) begin
				op_q   <= in_item.operation;
				cnt_q  <= len_sat;
				node_q <= (in_item.operation == htbd_pkg::OP_DECODE) ? cur_q : '0;
			end else if (cmd.clr_step) begin
				node_q <= node_q + htbd_pkg::NODE_W'(1);
			end else if (cmd.walk) begin
				cnt_q  <= cnt_q - htbd_pkg::LEN_W'(1);
				node_q <= absent ? used_q[htbd_pkg::NODE_W-1:0] : child;
				if (absent) begin
					used_q <= used_q + htbd_pkg::USED_W'(1);
				end
			end else if (cmd.dec_step) begin
				node_q <= child;
			end
			if (cmd.cur_root) begin
				cur_q <= '0;
			end else if (cmd.cur_node) begin
				cur_q <= node_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			bit_q  <= in_item.bit_req;
			sym_q  <= in_item.symbol;
			code_q <= in_item.code;
		end
		if (cmd.out_load) begin
			out_item.status         <= cmd.out_code;
			out_item.decoded_symbol <= (cmd.out_code == htbd_pkg::ST_OK) ? sym_rd : '0;
		end
	end

endmodule

// ----- src/htbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// htbd_ctrl
// Sequencer for store clearing, load walks and decode steps.
// ----------------------------------------------------------------------------
module htbd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  htbd_pkg::dp_stat_t stat,
	output htbd_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_L_WAIT,
		S_L_CHK,
		S_L_SYM,
		S_D_WAIT1,
		S_D_CHK1,
		S_D_WAIT2,
		S_D_CHK2
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = ~out_valid_q | ~out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (in_op == htbd_pkg::OP_DECODE) begin
						state_d = S_D_WAIT1;
					end else if (stat.in_len_zero) begin
						state_d = S_L_SYM;
					end else begin
						state_d = S_L_WAIT;
					end
				end
			end
			S_L_WAIT: state_d = S_L_CHK;
			S_L_CHK: begin
				if (stat.child_absent && stat.store_full) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_code = htbd_pkg::ST_FULL;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.walk = 1'b1;
					state_d  = stat.walk_last ? S_L_SYM : S_L_WAIT;
				end
			end
			S_L_SYM: begin
				cmd.sym_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_D_WAIT1: state_d = S_D_CHK1;
			S_D_CHK1: begin
				if (stat.child_absent) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_code = htbd_pkg::ST_BAD_PATH;
						cmd.cur_root = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.dec_step = 1'b1;
					state_d      = S_D_WAIT2;
				end
			end
			S_D_WAIT2: state_d = S_D_CHK2;
			S_D_CHK2: begin
				if (stat.is_leaf) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_code = htbd_pkg::ST_OK;
						cmd.cur_root = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.cur_node = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
